// ----- sv/scfa_pkg.sv -----
// Shared types, constants and helpers for the size class fit allocator.
package scfa_pkg;

  localparam int FREE_DEPTH  = 16;
  localparam int STACK_DEPTH = 16;
  localparam int FI_W = $clog2(FREE_DEPTH);
  localparam int FC_W = $clog2(FREE_DEPTH + 1);
  localparam int SI_W = $clog2(STACK_DEPTH);
  localparam int SC_W = $clog2(STACK_DEPTH + 1);

  localparam int SIZE_W = 16;
  localparam int ADDR_W = 32;
  localparam int STAT_W = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_REUSED     = 3'd0;
  localparam logic [STAT_W-1:0] ST_HEAP       = 3'd1;
  localparam logic [STAT_W-1:0] ST_FREED      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_FREE    = 3'd3;
  localparam logic [STAT_W-1:0] ST_HEAP_EXH   = 3'd4;
  localparam logic [STAT_W-1:0] ST_STACK_FULL = 3'd5;
  localparam logic [STAT_W-1:0] ST_FREE_FULL  = 3'd6;

  localparam int NUM_CLASSES = 5;
  localparam logic [SIZE_W-1:0] SIZE_CLASS [NUM_CLASSES] =
    '{16'd32, 16'd64, 16'd128, 16'd256, 16'd512};

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] request_size;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] block_size;
  } out_item_t;

  // One block: used for both free list and allocation stack entries
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } blk_t;

  localparam int BLK_W = $bits(blk_t);

  typedef struct packed {
    logic              load;
    logic              scan_init;
    logic              scan_run;
    logic              move_init;
    logic              move_run;
    logic              take_reuse;
    logic              take_heap;
    logic              free_push;
    logic              err;
    logic [STAT_W-1:0] err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic stack_full;
    logic stack_empty;
    logic free_empty;
    logic free_full;
    logic heap_ok;
    logic scan_done;
    logic found;
    logic move_done;
  } dp_sts_t;

  function automatic logic [SIZE_W-1:0] round_request(input logic [SIZE_W-1:0] req);
    logic [SIZE_W-1:0] r;
    r = req;
    for (int k = NUM_CLASSES - 1; k >= 0; k--) begin
      if (req <= SIZE_CLASS[k]) r = SIZE_CLASS[k];
    end
    return r;
  endfunction

endpackage

// ----- sv/size_class_fit_allocator.sv -----
// Sequence from accepted start to out_valid: an error found at decode ends there; a free commits
// in the free write state; an allocate with an empty free list goes to the heap; otherwise the free
// list is scanned and, on a hit, compacted before the grant, or the request falls back to the heap.
// One command at a time: busy stays high until the result strobe; the scan and the
// compaction each walk the free list memory one entry per cycle through its read port.
// Synchronous active-low reset clears both counts, fit_mode and heap pointer; heap limit to all ones.
module size_class_fit_allocator import scfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_data,
  output logic                  out_valid,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  scfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  scfa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

// ----- sv/scfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module scfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/scfa_ctrl.sv -----
// Command sequencer for the allocator: decide, scan, compact, grant or free.
module scfa_ctrl import scfa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output logic    out_valid,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_SCAN    = 3'd2;
  localparam logic [2:0] S_MOVE    = 3'd3;
  localparam logic [2:0] S_HEAP    = 3'd4;
  localparam logic [2:0] S_FREE_WR = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.is_free) begin
          if (sts.stack_empty) begin
            cmd.err      = 1'b1;
            cmd.err_code = ST_NO_FREE;
            state_nxt    = S_IDLE;
          end else if (sts.free_full) begin
            cmd.err      = 1'b1;
            cmd.err_code = ST_FREE_FULL;
            state_nxt    = S_IDLE;
          end else begin
            // stack top read is under way; commit next cycle
            state_nxt = S_FREE_WR;
          end
        end else if (sts.stack_full) begin
          cmd.err      = 1'b1;
          cmd.err_code = ST_STACK_FULL;
          state_nxt    = S_IDLE;
        end else if (sts.free_empty) begin
          state_nxt = S_HEAP;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.move_init = 1'b1;
            state_nxt     = S_MOVE;
          end else begin
            state_nxt = S_HEAP;
          end
        end
      end
      S_MOVE: begin
        cmd.move_run = 1'b1;
        if (sts.move_done) begin
          cmd.take_reuse = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_HEAP: begin
        if (sts.heap_ok) begin
          cmd.take_heap = 1'b1;
        end else begin
          cmd.err      = 1'b1;
          cmd.err_code = ST_HEAP_EXH;
        end
        state_nxt = S_IDLE;
      end
      S_FREE_WR: begin
        cmd.free_push = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (cmd.err || cmd.take_heap || cmd.take_reuse || cmd.free_push) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- sv/scfa_dp.sv -----
// Allocator datapath: registers, free list and stack memories, scan and compaction.
module scfa_dp import scfa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_sts_t               sts,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t             out_data
);

  logic              fit_mode_r;
  logic [ADDR_W-1:0] heap_ptr_r;
  logic [ADDR_W-1:0] heap_limit_r;
  logic [FC_W-1:0]   free_cnt_r;
  logic [SC_W-1:0]   stack_cnt_r;

  logic              cmd_free_r;
  logic [SIZE_W-1:0] size_r;

  logic [FC_W-1:0]   scan_idx_r;
  logic [FI_W-1:0]   cmp_idx_r;
  logic              cmp_vld_r;
  logic              found_r;
  logic [FI_W-1:0]   pick_idx_r;
  blk_t              pick_r;

  logic [FI_W-1:0]   mv_idx_r;
  logic [FI_W-1:0]   wr_addr_r;
  logic              wr_pend_r;

  out_item_t         out_r;

  blk_t              free_rdata, stack_rdata, free_wdata, stack_wdata;
  logic              free_we, stack_we;
  logic [FI_W-1:0]   free_waddr, free_raddr;
  logic [SC_W-1:0]   stack_top;

  logic              fits, hit, scan_issue, last_cmp, mv_issue;
  logic [FC_W-1:0]   mv_next;
  logic [ADDR_W:0]   heap_sum;

  assign fits = free_rdata.size >= size_r;
  // best fit keeps the earliest of equal sizes: strictly smaller only
  assign hit  = cmp_vld_r && fits &&
                (!found_r || (fit_mode_r && (free_rdata.size < pick_r.size)));
  assign scan_issue = scan_idx_r < free_cnt_r;
  assign last_cmp   = (FC_W'(cmp_idx_r) + FC_W'(1)) == free_cnt_r;
  assign mv_next    = FC_W'(mv_idx_r) + FC_W'(1);
  assign mv_issue   = mv_next < free_cnt_r;
  assign heap_sum   = {1'b0, heap_ptr_r} + (ADDR_W + 1)'(size_r);
  assign stack_top  = stack_cnt_r - SC_W'(1);

  always_comb begin
    sts.is_free     = cmd_free_r;
    sts.stack_full  = stack_cnt_r == SC_W'(STACK_DEPTH);
    sts.stack_empty = stack_cnt_r == '0;
    sts.free_empty  = free_cnt_r == '0;
    sts.free_full   = free_cnt_r == FC_W'(FREE_DEPTH);
    sts.heap_ok     = heap_sum <= {1'b0, heap_limit_r};
    sts.scan_done   = cmp_vld_r && (last_cmp || (!fit_mode_r && fits));
    sts.found       = found_r || (cmp_vld_r && fits);
    sts.move_done   = !mv_issue && !wr_pend_r;
  end

  always_comb begin
    if (cmd.scan_init)     free_raddr = '0;
    else if (cmd.move_run) free_raddr = mv_next[FI_W-1:0];
    else                   free_raddr = scan_idx_r[FI_W-1:0];

    free_we    = cmd.free_push || (cmd.move_run && wr_pend_r);
    free_waddr = cmd.free_push ? free_cnt_r[FI_W-1:0] : wr_addr_r;
    free_wdata = cmd.free_push ? stack_rdata : free_rdata;

    stack_we         = cmd.take_reuse || cmd.take_heap;
    stack_wdata.size = cmd.take_reuse ? pick_r.size : size_r;
    stack_wdata.addr = cmd.take_reuse ? pick_r.addr : heap_ptr_r;
  end

  scfa_ram #(.WIDTH(BLK_W), .DEPTH(FREE_DEPTH)) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (free_wdata),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

  scfa_ram #(.WIDTH(BLK_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_cnt_r[SI_W-1:0]),
    .wdata (stack_wdata),
    .raddr (stack_top[SI_W-1:0]),
    .rdata (stack_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r   <= 1'b0;
      heap_ptr_r   <= '0;
      heap_limit_r <= '1;
      free_cnt_r   <= '0;
      stack_cnt_r  <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      wr_pend_r    <= 1'b0;
    end else begin
      if (cmd.scan_init) begin
        cmp_vld_r <= 1'b1;
        found_r   <= 1'b0;
      end else if (cmd.scan_run) begin
        cmp_vld_r <= scan_issue;
        if (hit) found_r <= 1'b1;
      end

      if (cmd.move_init)     wr_pend_r <= 1'b0;
      else if (cmd.move_run) wr_pend_r <= mv_issue;

      if (cmd.take_reuse) begin
        free_cnt_r  <= free_cnt_r - FC_W'(1);
        stack_cnt_r <= stack_cnt_r + SC_W'(1);
      end
      if (cmd.take_heap) begin
        stack_cnt_r <= stack_cnt_r + SC_W'(1);
        heap_ptr_r  <= heap_sum[ADDR_W-1:0];
      end
      if (cmd.free_push) begin
        free_cnt_r  <= free_cnt_r + FC_W'(1);
        stack_cnt_r <= stack_top;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_FIT_MODE:   fit_mode_r   <= cfg_data[0];
          REG_HEAP_BASE:  heap_ptr_r   <= cfg_data;
          REG_HEAP_LIMIT: heap_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_free_r <= in_data.command == CMD_FREE;
      size_r     <= round_request(in_data.request_size);
    end

    if (cmd.scan_init) begin
      scan_idx_r <= FC_W'(1);
      cmp_idx_r  <= '0;
    end else if (cmd.scan_run) begin
      cmp_idx_r <= scan_idx_r[FI_W-1:0];
      if (scan_issue) scan_idx_r <= scan_idx_r + FC_W'(1);
    end
    if (cmd.scan_run && hit) begin
      pick_idx_r <= cmp_idx_r;
      pick_r     <= free_rdata;
    end

    if (cmd.move_init) begin
      mv_idx_r <= hit ? cmp_idx_r : pick_idx_r;
    end else if (cmd.move_run && mv_issue) begin
      wr_addr_r <= mv_idx_r;
      mv_idx_r  <= mv_next[FI_W-1:0];
    end

    if (cmd.take_reuse) begin
      out_r.status     <= ST_REUSED;
      out_r.address    <= pick_r.addr;
      out_r.block_size <= pick_r.size;
    end else if (cmd.take_heap) begin
      out_r.status     <= ST_HEAP;
      out_r.address    <= heap_ptr_r;
      out_r.block_size <= size_r;
    end else if (cmd.free_push) begin
      out_r.status     <= ST_FREED;
      out_r.address    <= stack_rdata.addr;
      out_r.block_size <= stack_rdata.size;
    end else if (cmd.err) begin
      out_r.status     <= cmd.err_code;
      out_r.address    <= '0;
      out_r.block_size <= cmd_free_r ? '0 : size_r;
    end
  end

  assign out_data = out_r;

endmodule

// ----- sv/scfa_checker.sv -----
// Port-level checks for the allocator, bound to the top level.
module scfa_checker import scfa_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_item_t              in_data,
  input logic                  out_valid,
  input out_item_t             out_data,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("request accepted but block not busy");

  // one result per request: strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FREE_FULL)
    else $error("undefined status code");

  a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_FREE || out_data.status == ST_HEAP_EXH ||
                  out_data.status == ST_STACK_FULL || out_data.status == ST_FREE_FULL)
    |-> out_data.address == '0)
    else $error("error result with nonzero address");

  a_free_err_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NO_FREE || out_data.status == ST_FREE_FULL)
    |-> out_data.block_size == '0)
    else $error("free error with nonzero block size");

endmodule

bind size_class_fit_allocator scfa_checker u_scfa_checker (.*);

// ----- verif/tb_size_class_fit_allocator.sv -----
// Self-checking testbench for the size class fit allocator: directed and random requests.
module tb_size_class_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import scfa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * FREE_DEPTH + 8;
  localparam int MAX_REPORTS    = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  in_item_t              in_data = '0;
  logic                  out_valid;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  size_class_fit_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Shadow copy of the allocator state
  logic              best_fit;
  logic [ADDR_W-1:0] heap_limit_reg;
  logic [ADDR_W-1:0] heap_ptr;
  logic [SIZE_W-1:0] free_sz  [FREE_DEPTH];
  logic [ADDR_W-1:0] free_ad  [FREE_DEPTH];
  int                free_n;
  logic [SIZE_W-1:0] grant_sz [STACK_DEPTH];
  logic [ADDR_W-1:0] grant_ad [STACK_DEPTH];
  int                grant_n;

  out_item_t expected_grants[$];
  int        mismatches = 0;
  int        stall_cycles = 0;
  bit        gaps_on = 1'b1;

  function automatic logic [SIZE_W-1:0] size_class_of(input logic [SIZE_W-1:0] req);
    if (req > 16'd512) return req;
    if (req <= 16'd32) return 16'd32;
    if (req <= 16'd64) return 16'd64;
    if (req <= 16'd128) return 16'd128;
    if (req <= 16'd256) return 16'd256;
    return 16'd512;
  endfunction

  function automatic out_item_t predict_grant(input in_item_t req);
    out_item_t         r;
    logic [SIZE_W-1:0] sz;
    int                pick;
    r = '0;
    if (req.command == CMD_ALLOC) begin
      sz = size_class_of(req.request_size);
      pick = -1;
      if (grant_n >= STACK_DEPTH) begin
        r.status = ST_STACK_FULL;
        r.block_size = sz;
        return r;
      end
      // first fit keeps the first hit; best fit moves only to a strictly smaller one
      for (int k = 0; k < free_n; k++) begin
        if (free_sz[k] >= sz && (pick < 0 || (best_fit && free_sz[k] < free_sz[pick])))
          pick = k;
      end
      if (pick >= 0) begin
        r.status = ST_REUSED;
        r.address = free_ad[pick];
        r.block_size = free_sz[pick];
        for (int k = pick; k < free_n - 1; k++) begin
          free_sz[k] = free_sz[k + 1];
          free_ad[k] = free_ad[k + 1];
        end
        free_n--;
        grant_ad[grant_n] = r.address;
        grant_sz[grant_n] = r.block_size;
        grant_n++;
      end else if ({1'b0, heap_ptr} + {17'b0, sz} > {1'b0, heap_limit_reg}) begin
        r.status = ST_HEAP_EXH;
        r.block_size = sz;
      end else begin
        r.status = ST_HEAP;
        r.address = heap_ptr;
        r.block_size = sz;
        heap_ptr = heap_ptr + ADDR_W'(sz);
        grant_ad[grant_n] = r.address;
        grant_sz[grant_n] = sz;
        grant_n++;
      end
    end else if (grant_n == 0) begin
      r.status = ST_NO_FREE;
    end else if (free_n >= FREE_DEPTH) begin
      r.status = ST_FREE_FULL;
    end else begin
      grant_n--;
      free_ad[free_n] = grant_ad[grant_n];
      free_sz[free_n] = grant_sz[grant_n];
      free_n++;
      r.status = ST_FREED;
      r.address = grant_ad[grant_n];
      r.block_size = grant_sz[grant_n];
    end
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    logic [SIZE_W-1:0] boundary;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SIZE_W'($urandom_range(0, 512));
      4, 5: begin
        boundary = 16'd32 << $urandom_range(0, 4);
        return SIZE_W'({16'd0, boundary} + $urandom_range(0, 2) - 32'd1);
      end
      6, 7: return SIZE_W'($urandom_range(513, 4096));
      default: return SIZE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic sender_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
    end
  endtask

  // start stays high after acceptance; the next request or a gap sets it at the next fall
  task automatic send_request(input logic cmd, input logic [SIZE_W-1:0] sz);
    in_item_t item;
    item.command = cmd;
    item.request_size = sz;
    sender_gap();
    @(negedge clk);
    start <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    expected_grants.insert(expected_grants.size(), predict_grant(item));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FIT_MODE: best_fit = val[0];
      REG_HEAP_BASE: heap_ptr = val;
      REG_HEAP_LIMIT: heap_limit_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input logic [ADDR_W-1:0] base,
                            input logic [ADDR_W-1:0] limit);
    wait_idle();
    // upper bits of the mode write are don't-care
    write_reg(REG_FIT_MODE, {$urandom_range(0, 1) ? 31'($urandom) : 31'd0, mode});
    write_reg(REG_HEAP_BASE, base);
    write_reg(REG_HEAP_LIMIT, limit);
  endtask

  task automatic random_churn(input int n_items);
    int left;
    int run;
    bit favor_free;
    left = n_items;
    while (left > 0) begin
      favor_free = $urandom_range(0, 1);
      run = $urandom_range(1, 20);
      for (int i = 0; i < run && left > 0; i++) begin
        send_request(($urandom_range(0, 99) < 80) ? favor_free : !favor_free, random_size());
        left--;
      end
    end
  endtask

  task automatic log_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t mismatch (%s): exp st %0d addr %h size %0d, got st %0d addr %h size %0d",
               $time, what, want.status, want.address, want.block_size,
               got.status, got.address, got.block_size);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_grants.size() == 0) begin
        log_mismatch("unexpected result", '0, out_data);
      end else begin
        want = expected_grants.pop_front();
        if (out_data.status !== want.status || out_data.address !== want.address ||
            out_data.block_size !== want.block_size)
          log_mismatch("field", want, out_data);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && busy === 1'b0) || out_valid === 1'b1)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_size_classes();
    logic [SIZE_W-1:0] sizes [14] = '{16'd0, 16'd1, 16'd32, 16'd33, 16'd64, 16'd65, 16'd128,
                                      16'd129, 16'd256, 16'd257, 16'd511, 16'd512, 16'd513,
                                      16'd65535};
    send_request(CMD_FREE, 16'hFFFF);  // empty stack
    foreach (sizes[i]) send_request(CMD_ALLOC, sizes[i]);
  endtask

  task automatic test_reuse_and_fit();
    repeat (4) send_request(CMD_FREE, 16'd0);
    // first fit takes the oversized block at the head of the table
    send_request(CMD_ALLOC, 16'd100);
    send_request(CMD_FREE, 16'd0);
    wait_idle();
    write_reg(REG_FIT_MODE, 32'd1);
    // two 512 entries tie, the earlier must win
    send_request(CMD_ALLOC, 16'd300);
    send_request(CMD_FREE, 16'd0);
  endtask

  task automatic test_heap_exhaustion();
    wait_idle();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FF00);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 16'hFFFF);
    send_request(CMD_ALLOC, 16'd600);  // would wrap past the top
    wait_idle();
    write_reg(REG_HEAP_LIMIT, 32'd0);
    write_reg(REG_HEAP_BASE, 32'd0);
    send_request(CMD_ALLOC, 16'd1000);
    wait_idle();
    write_reg(REG_HEAP_BASE, 32'hFFFF_FFFF);
    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, 16'd700);
  endtask

  task automatic test_stack_and_table_limits();
    set_config(1'b0, $urandom_range(0, 32'h00FF_FFFF), 32'hFFFF_FFFF);
    repeat (3) begin
      repeat (18) send_request(CMD_ALLOC, random_size());
      repeat (18) send_request(CMD_FREE, random_size());
      // large requests take a table entry only if one is as large; else the stack grows while the table stays full
      repeat (6) send_request(CMD_ALLOC, SIZE_W'($urandom_range(4097, 65535)));
      repeat (3) send_request(CMD_FREE, random_size());
    end
  endtask

  task automatic test_first_fit_open_heap();
    set_config(1'b0, 32'd0, 32'hFFFF_FFFF);
    random_churn(400);
  endtask

  task automatic test_best_fit_tight_heap();
    logic [ADDR_W:0] lim;
    logic [ADDR_W-1:0] base;
    base = $urandom;
    lim = {1'b0, base} + {1'b0, $urandom_range(2048, 65536)};
    set_config(1'b1, base, lim[ADDR_W] ? 32'hFFFF_FFFF : lim[ADDR_W-1:0]);
    random_churn(350);
  endtask

  task automatic test_heap_top_no_wrap();
    set_config(1'b1, 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF), 32'hFFFF_FFFF);
    random_churn(300);
  endtask

  task automatic test_random_limit_and_unmapped_reg();
    set_config(1'b0, $urandom, $urandom);
    write_reg(REG_UNMAPPED, $urandom);
    random_churn(300);
    wait_idle();
    write_reg(REG_UNMAPPED, $urandom);
    random_churn(50);
  endtask

  task automatic test_back_to_back();
    set_config(1'($urandom_range(0, 1)), 32'd0, 32'hFFFF_FFFF);
    gaps_on = 1'b0;
    random_churn(400);
  endtask

  initial begin
    best_fit = 1'b0;
    heap_limit_reg = 32'hFFFF_FFFF;
    heap_ptr = '0;
    free_n = 0;
    grant_n = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_size_classes();
    test_reuse_and_fit();
    test_heap_exhaustion();
    test_stack_and_table_limits();
    test_first_fit_open_heap();
    test_best_fit_tight_heap();
    test_heap_top_no_wrap();
    test_random_limit_and_unmapped_reg();
    test_back_to_back();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/scfa_pkg.sv
sv/scfa_ram.sv
sv/scfa_ctrl.sv
sv/scfa_dp.sv
sv/size_class_fit_allocator.sv
sv/scfa_checker.sv
verif/tb_size_class_fit_allocator.sv
